// ===== design/stm_pkg.sv =====
// Shared types and constants for the saturating track mixer.
`timescale 1ns / 1ps
`default_nettype none
package stm_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ACCUM = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] CFG_BUFFER_LENGTH   = 2'd0;
  localparam logic [1:0] CFG_CHANNELS_IN_USE = 2'd1;
  localparam logic [1:0] CFG_FORMAT_IS_S16   = 2'd2;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  localparam logic [12:0] BUFFER_LENGTH_RST   = 13'd4096;
  localparam logic [3:0]  CHANNELS_IN_USE_RST = 4'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [2:0]         channel;
    logic [11:0]        position;
    logic [11:0]        start_offset;
    logic signed [15:0] track_sample;
    logic [15:0]        gain;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] read_sample;
    logic               clipped;
    logic               status;
  } out_word_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_ACCUM,
    CMD_READ,
    CMD_DROP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [2:0]         channel;
    logic [12:0]        target;
    logic signed [15:0] track_sample;
    logic [15:0]        gain;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_FINISH
  } back_state_t;

endpackage
`default_nettype wire

// ===== design/stm_front.sv =====
// Front end: configuration registers, target computation and range checks.
`timescale 1ns / 1ps
`default_nettype none
module stm_front #(
  parameter int MAX_CHANNELS = 8,
  parameter int BUF_SAMPLES  = 4096
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [1:0]           cfg_index,
  input  wire  [12:0]          cfg_data,
  input  stm_pkg::in_word_t    in_word,
  output stm_pkg::cmd_t        cmd
);
  import stm_pkg::*;

  logic [12:0] len_r;
  logic [3:0]  chan_r;
  logic        fmt_r;
  logic [12:0] target;
  logic        in_range;
  logic        drop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= BUFFER_LENGTH_RST;
      chan_r <= CHANNELS_IN_USE_RST;
      fmt_r  <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BUFFER_LENGTH:   len_r  <= cfg_data;
        CFG_CHANNELS_IN_USE: chan_r <= cfg_data[3:0];
        CFG_FORMAT_IS_S16:   fmt_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_word.operation == OP_ACCUM) begin
      target = 13'(in_word.position) + 13'(in_word.start_offset);
    end else begin
      target = {1'b0, in_word.position};
    end
    in_range = (32'(in_word.channel) < 32'(chan_r)) &&
               (32'(in_word.channel) < MAX_CHANNELS) &&
               (32'(target) < 32'(len_r)) &&
               (32'(target) < BUF_SAMPLES);
    drop = !in_range || (in_word.operation == OP_ACCUM && !fmt_r);

    cmd.channel      = in_word.channel;
    cmd.target       = target;
    cmd.track_sample = in_word.track_sample;
    cmd.gain         = in_word.gain;
    if (drop) begin
      cmd.kind = CMD_DROP;
    end else begin
      unique case (in_word.operation)
        OP_CLEAR: cmd.kind = CMD_CLEAR;
        OP_ACCUM: cmd.kind = CMD_ACCUM;
        OP_READ:  cmd.kind = CMD_READ;
        default:  cmd.kind = CMD_DROP;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/stm_queue.sv =====
// Two-entry command queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module stm_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  stm_pkg::cmd_t  push_cmd,
  output logic           full,
  input  wire            pop,
  output stm_pkg::cmd_t  head,
  output logic           empty
);
  import stm_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule
`default_nettype wire

// ===== design/stm_back.sv =====
// Back end: mix buffer memory, gain scaling, saturating add and result register.
`timescale 1ns / 1ps
`default_nettype none
module stm_back #(
  parameter int MAX_CHANNELS   = 8,
  parameter int BUF_SAMPLES    = 4096,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  stm_pkg::cmd_t       head,
  input  wire                 q_empty,
  output logic                q_pop,
  output logic                out_empty,
  input  wire                 out_pop,
  output stm_pkg::out_word_t  out_word
);
  import stm_pkg::*;

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int TGT_W  = $clog2(BUF_SAMPLES);
  localparam int DEPTH  = MAX_CHANNELS * (2 ** TGT_W);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SMAG_W = 33 - GAIN_FRAC_BITS;
  localparam int SUM_W  = SMAG_W + 2;

  back_state_t        state_r;
  back_state_t        state_nxt;
  cmd_t               cur_r;
  logic [15:0]        mem [DEPTH];
  logic signed [15:0] rd_data_r;
  logic [32:0]        prod_r;
  logic               ov_r;
  out_word_t          out_r;

  logic [ADDR_W-1:0]       addr;
  logic [16:0]             mag;
  logic [SMAG_W-1:0]       smag;
  logic signed [SUM_W-1:0] scaled;
  logic signed [SUM_W-1:0] sum;
  logic signed [15:0]      sat;
  logic                    clip;
  logic                    room;
  logic                    mem_re;
  logic                    fin_go;
  logic                    mem_we;
  logic [15:0]             mem_wdata;
  out_word_t               res;

  assign room      = !ov_r || out_pop;
  assign out_empty = !ov_r;
  assign out_word  = out_r;
  assign addr      = ADDR_W'({CH_W'(cur_r.channel), TGT_W'(cur_r.target)});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (!q_empty) state_nxt = BK_READ;
      BK_READ:   state_nxt = BK_FINISH;
      BK_FINISH: if (room) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = (state_r == BK_IDLE) && !q_empty;
    mem_re = (state_r == BK_READ);
    fin_go = (state_r == BK_FINISH) && room;
  end

  always_comb begin
    if (cur_r.track_sample[15]) begin
      mag = 17'(-{cur_r.track_sample[15], cur_r.track_sample});
    end else begin
      mag = {1'b0, cur_r.track_sample};
    end
    smag = prod_r[32:GAIN_FRAC_BITS];
    if (cur_r.track_sample[15]) begin
      scaled = -$signed({2'b00, smag});
    end else begin
      scaled = $signed({2'b00, smag});
    end
    sum = SUM_W'(rd_data_r) + scaled;
    if (sum > SAMPLE_MAX) begin
      sat  = 16'(SAMPLE_MAX);
      clip = 1'b1;
    end else if (sum < SAMPLE_MIN) begin
      sat  = 16'(SAMPLE_MIN);
      clip = 1'b1;
    end else begin
      sat  = sum[15:0];
      clip = 1'b0;
    end

    res       = '0;
    mem_we    = 1'b0;
    mem_wdata = '0;
    unique case (cur_r.kind)
      CMD_CLEAR: mem_we = fin_go;
      CMD_ACCUM: begin
        mem_we          = fin_go;
        mem_wdata       = sat;
        res.read_sample = sat;
        res.clipped     = clip;
      end
      CMD_READ:  res.read_sample = rd_data_r;
      CMD_DROP:  res.status = 1'b1;
      default:   res.status = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        ov_r <= 1'b1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= head;
    if (mem_re) prod_r <= {16'b0, mag} * {17'b0, cur_r.gain};
    if (fin_go) out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= mem_wdata;
    if (mem_re) rd_data_r <= $signed(mem[addr]);
  end

endmodule
`default_nettype wire

// ===== design/saturating_track_mixer.sv =====
// Top level of the saturating track mixer.
// Usage:
//   Input words (in_word) enter while in_full is low by raising in_push; each
//   is a clear, accumulate or read of one mix buffer entry. Results leave as a
//   queue: while out_empty is low, out_word holds the oldest result, taken by
//   raising out_pop. Every input word yields exactly one result word.
//   Configuration registers are written through cfg_valid/cfg_index/cfg_data;
//   cfg_ready is always high. Write them only while the block is idle.
//   An accepted word passes the command queue, the back end's command register,
//   its read and product registers and the result register. The back end takes
//   no new word until its read-modify-write on the single-port mix buffer ends.
//   A two-entry command queue lets input words be accepted while the back end
//   works or while a result waits; when out_pop stays low, the back end holds
//   its finished word, the queue fills and in_full rises.
//   Reset restores length 4096, two channels and S16 format and empties the
//   queues; buffer contents are undefined until each entry is cleared.
`timescale 1ns / 1ps
`default_nettype none
module saturating_track_mixer #(
  parameter int MAX_CHANNELS   = 8,
  parameter int BUF_SAMPLES    = 4096,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_push,
  output logic                in_full,
  input  stm_pkg::in_word_t   in_word,
  output logic                out_empty,
  input  wire                 out_pop,
  output stm_pkg::out_word_t  out_word,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [12:0]         cfg_data
);
  import stm_pkg::*;

  cmd_t front_cmd;
  cmd_t head;
  logic q_empty;
  logic q_pop;

  stm_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .BUF_SAMPLES  (BUF_SAMPLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (front_cmd)
  );

  stm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .push_cmd (front_cmd),
    .full     (in_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  stm_back #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .BUF_SAMPLES    (BUF_SAMPLES),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

// ===== bench/tb_saturating_track_mixer.sv =====
// Self-checking testbench for the saturating track mixer: directed and random words.
`timescale 1ns / 1ps
module tb_saturating_track_mixer;
  import stm_pkg::*;

  localparam int MAX_CHANNELS   = 8;
  localparam int BUF_SAMPLES    = 4096;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int NUM_ENTRIES    = MAX_CHANNELS * BUF_SAMPLES;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOT_SPAN       = 24;
  localparam int RAND_PER_CFG   = 105;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  in_word_t    in_word = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  out_word_t   out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_BUFFER_LENGTH;
  logic [12:0] cfg_data = '0;

  // shadow of the block
  logic signed [15:0] mix_shadow [NUM_ENTRIES];
  bit                 entry_cleared [NUM_ENTRIES];
  logic [12:0]        len_reg = BUFFER_LENGTH_RST;
  logic [3:0]         nch_reg = CHANNELS_IN_USE_RST;
  logic               fmt_reg = 1'b1;

  out_word_t pending_mixes [$];
  out_word_t oldest_mix;
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_req = 0;
  int        hold_ack = 0;
  int        hold_cnt = 0;
  int        quiet_cycles = 0;

  saturating_track_mixer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_len();
    return (len_reg > BUF_SAMPLES) ? BUF_SAMPLES : int'(len_reg);
  endfunction

  function automatic int eff_nch();
    return (nch_reg > MAX_CHANNELS) ? MAX_CHANNELS : int'(nch_reg);
  endfunction

  // buffer entry a word addresses, -1 when out of range
  function automatic int entry_of(in_word_t w);
    logic [12:0] tgt;
    tgt = (w.operation == OP_ACCUM) ? 13'(w.position) + 13'(w.start_offset)
                                    : 13'(w.position);
    if (int'(w.channel) < eff_nch() && int'(tgt) < eff_len())
      return int'(w.channel) * BUF_SAMPLES + int'(tgt);
    return -1;
  endfunction

  function automatic out_word_t mix_predict(in_word_t w);
    out_word_t r;
    int        idx;
    longint    mag;
    longint    scaled;
    longint    sum;
    r = '0;
    r.status = 1'b1;
    idx = entry_of(w);
    if (idx >= 0 && (w.operation == OP_CLEAR || w.operation == OP_READ ||
                     (w.operation == OP_ACCUM && fmt_reg))) begin
      r.status = 1'b0;
      case (w.operation)
        OP_CLEAR: begin
          mix_shadow[idx] = '0;
          entry_cleared[idx] = 1'b1;
        end
        OP_READ: begin
          r.read_sample = mix_shadow[idx];
        end
        default: begin
          mag = longint'($signed(w.track_sample));
          if (mag < 0) mag = -mag;
          scaled = (mag * longint'(w.gain)) >> GAIN_FRAC_BITS;
          if ($signed(w.track_sample) < 0) scaled = -scaled;
          sum = longint'(mix_shadow[idx]) + scaled;
          if (sum > SAMPLE_MAX) begin
            sum = SAMPLE_MAX;
            r.clipped = 1'b1;
          end else if (sum < SAMPLE_MIN) begin
            sum = SAMPLE_MIN;
            r.clipped = 1'b1;
          end
          mix_shadow[idx] = sum[15:0];
          r.read_sample = sum[15:0];
        end
      endcase
    end
    return r;
  endfunction

  function automatic in_word_t make_word(logic [1:0] op, int ch, int pos, int off,
                                         int sample, int gain);
    in_word_t w;
    w.operation    = op;
    w.channel      = 3'(ch);
    w.position     = 12'(pos);
    w.start_offset = 12'(off);
    w.track_sample = 16'(sample);
    w.gain         = 16'(gain);
    return w;
  endfunction

  function automatic in_word_t gen_item();
    in_word_t w;
    int       pick;
    int       lim;
    int       t;
    int       off;
    pick = $urandom_range(0, 99);
    w.operation = (pick < 20) ? OP_CLEAR : (pick < 62) ? OP_ACCUM :
                  (pick < 92) ? OP_READ : OP_UNUSED;
    lim = (eff_len() < HOT_SPAN) ? eff_len() : HOT_SPAN;
    if (lim == 0) lim = HOT_SPAN;
    t = $urandom_range(0, lim - 1);
    if ($urandom_range(0, 9) == 0) w.channel = 3'($urandom);
    else w.channel = 3'($urandom_range(0, eff_nch()));
    if (w.operation == OP_ACCUM) begin
      off = $urandom_range(0, t);
      w.start_offset = 12'(off);
      w.position = 12'(t - off);
    end else begin
      w.start_offset = 12'($urandom);
      w.position = 12'(t);
    end
    if ($urandom_range(0, 9) == 0) begin
      w.position = 12'($urandom);
      w.start_offset = 12'($urandom);
    end
    case ($urandom_range(0, 3))
      0: w.track_sample = 16'($urandom);
      1: w.track_sample = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      2: w.track_sample = 16'($urandom_range(0, 600)) - 16'd300;
      default: w.track_sample = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: w.gain = 16'($urandom);
      1: w.gain = 16'd4096;
      2: w.gain = 16'($urandom_range(0, 4096));
      default: w.gain = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
    return w;
  endfunction

  // presents one word, waits for it to be taken; push stays high on return
  task automatic send_word(input in_word_t w);
    int gap;
    int idx;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // never read or accumulate an entry that has not been cleared; clear it instead
    idx = entry_of(w);
    if (idx >= 0 && !entry_cleared[idx] &&
        (w.operation == OP_READ || w.operation == OP_ACCUM)) begin
      w.position = 12'(idx % BUF_SAMPLES);
      w.operation = OP_CLEAR;
    end
    in_push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_full);
    pending_mixes.push_back(mix_predict(w));
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (pending_mixes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BUFFER_LENGTH:   len_reg = data;
      CFG_CHANNELS_IN_USE: nch_reg = data[3:0];
      default:             fmt_reg = data[0];
    endcase
  endtask

  task automatic set_config(input logic [12:0] len, input logic [3:0] nch, input logic fmt);
    write_reg(CFG_BUFFER_LENGTH, len);
    write_reg(CFG_CHANNELS_IN_USE, 13'(nch));
    write_reg(CFG_FORMAT_IS_S16, 13'(fmt));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(input int n);
    repeat (n) send_word(gen_item());
    wait_drained();
  endtask

  task automatic test_defaults();
    send_word(make_word(OP_CLEAR, 0, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 0, 0, 4095, -1, 65535));
    send_word(make_word(OP_CLEAR, 1, 4095, 0, 0, 0));
    send_word(make_word(OP_ACCUM, 1, 4095, 0, 32767, 65535));
    send_word(make_word(OP_READ, 1, 4095, 0, 0, 0));
    send_word(make_word(OP_CLEAR, 2, 0, 0, 0, 0));
    send_word(make_word(OP_UNUSED, 0, 0, 0, 0, 0));
    send_word(make_word(OP_ACCUM, 1, 4095, 1, 100, 4096));
    wait_drained();
  endtask

  task automatic test_scaling();
    set_config(BUFFER_LENGTH_RST, CHANNELS_IN_USE_RST, 1'b1);
    send_word(make_word(OP_ACCUM, 0, 0, 0, -1, 1));
    send_word(make_word(OP_ACCUM, 0, 0, 0, -3, 2048));
    send_word(make_word(OP_ACCUM, 0, 0, 0, 3, 2048));
    send_word(make_word(OP_ACCUM, 0, 0, 0, -32768, 65535));
    send_word(make_word(OP_ACCUM, 0, 0, 0, 32767, 0));
    send_word(make_word(OP_ACCUM, 0, 0, 0, 12345, 4096));
    wait_drained();
  endtask

  task automatic test_config_extremes();
    set_config(13'd8191, 4'd15, 1'b0);
    send_word(make_word(OP_CLEAR, 7, 4095, 0, 0, 0));
    send_word(make_word(OP_ACCUM, 7, 4000, 95, 1000, 4096));
    send_word(make_word(OP_READ, 7, 4095, 0, 0, 0));
    wait_drained();
    set_config(13'd0, 4'd1, 1'b1);
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0));
    send_word(make_word(OP_CLEAR, 0, 0, 0, 0, 0));
    wait_drained();
    set_config(13'd1, 4'd1, 1'b1);
    send_word(make_word(OP_ACCUM, 0, 0, 0, -20000, 8192));
    send_word(make_word(OP_READ, 0, 1, 0, 0, 0));
    send_word(make_word(OP_ACCUM, 0, 0, 1, 5, 4096));
    wait_drained();
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_config(13'd4096, 4'd2, 1'b1);
    random_items(RAND_PER_CFG);
    set_config(13'd32, 4'd8, 1'b1);
    random_items(RAND_PER_CFG);
    set_config(13'd1, 4'd1, 1'b1);
    random_items(RAND_PER_CFG);
    set_config(13'd200, 4'd15, 1'b0);
    random_items(RAND_PER_CFG);
    set_config(13'd8191, 4'd8, 1'b1);
    random_items(RAND_PER_CFG);
  endtask

  task automatic test_random_traffic();
    run_random_phase(25, 88);
    run_random_phase(88, 25);
    run_random_phase(0, 0);
  endtask

  // receiver stalls for a long stretch while words keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(13'd64, 4'd8, 1'b1);
    hold_req++;
    random_items(40);
  endtask

  // result side: check the popped word, then decide on the next pop
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_mixes.size() == 0) begin
          $error("unexpected result word: read_sample %0d", out_word.read_sample);
          mismatch_count++;
        end else begin
          oldest_mix = pending_mixes.pop_front();
          if (out_word.read_sample !== oldest_mix.read_sample) begin
            $error("read_sample: expected %0d, got %0d",
                   oldest_mix.read_sample, out_word.read_sample);
            mismatch_count++;
          end
          if (out_word.clipped !== oldest_mix.clipped) begin
            $error("clipped: expected %0d, got %0d", oldest_mix.clipped, out_word.clipped);
            mismatch_count++;
          end
          if (out_word.status !== oldest_mix.status) begin
            $error("status: expected %0d, got %0d", oldest_mix.status, out_word.status);
            mismatch_count++;
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 25;
    recv_idle_pct = 88;
    test_defaults();
    test_scaling();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_mixes.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
design/stm_pkg.sv
design/stm_front.sv
design/stm_queue.sv
design/stm_back.sv
design/saturating_track_mixer.sv
bench/tb_saturating_track_mixer.sv
